### hdl/assert_macros.svh
// Shared assertion macros for the scheduler checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define DRS_AST_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Check cons in the cycle after ante.
`define DRS_AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

### hdl/drs_pkg.sv
package drs_pkg;

    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int CYL_W     = 16;
    localparam int ADR_W     = 32;
    localparam int PROC_W    = 16;
    localparam int POL_W     = 2;
    localparam int CNT_OUT_W = 5;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int KEY_W     = 1 + CYL_W + TIME_W;

    localparam logic [POL_W-1:0] POL_FCFS = 2'd0;
    localparam logic [POL_W-1:0] POL_SSTF = 2'd1;

    localparam logic REG_POLICY = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [CYL_W-1:0]  cylinder;
        logic [ADR_W-1:0]  address;
        logic [PROC_W-1:0] process;
    } t_entry;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic [CYL_W-1:0] head;
        logic             up;
        logic [POL_W-1:0] policy;
    } t_pick_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_TAKE,
        ST_SHIFT,
        ST_MVLAST,
        ST_RESP
    } t_state;

endpackage

### hdl/disk_request_scheduler_unit.sv
// Disk request scheduler: one request in service plus a queue of QUEUE_DEPTH
// waiting requests, chosen by FCFS, SSTF or LOOK per the policy register.
// An item is taken when start is high and busy is low; its single result is
// shown for exactly one cycle with o_done high and must be captured then, as
// the block cannot be stalled. An arrival's result follows in the cycle after
// its transfer, as does that of a completion with an empty queue. A completion
// with queued requests first has one compare unit walk the queue memory one
// slot per cycle through its single read port; when the chosen request is not
// the last queued one, the later slots then move down one per cycle through
// the same port.
module disk_request_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           start,
    output logic                           busy,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [drs_pkg::APB_AW-1:0]     paddr,
    input  logic [drs_pkg::APB_DW-1:0]     pwdata,
    output logic [drs_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,

    input  logic                           i_mode,
    input  logic [drs_pkg::ID_W-1:0]       i_new_request_id,
    input  logic [drs_pkg::TIME_W-1:0]     i_new_arrival_time,
    input  logic [drs_pkg::CYL_W-1:0]      i_new_cylinder,
    input  logic [drs_pkg::ADR_W-1:0]      i_new_address,
    input  logic [drs_pkg::PROC_W-1:0]     i_new_process,
    input  logic [drs_pkg::CYL_W-1:0]      i_head_cylinder,
    input  logic                           i_scan_direction,

    output logic                           o_done,
    output logic                           o_busy_res,
    output logic [drs_pkg::ID_W-1:0]       o_served_id,
    output logic [drs_pkg::TIME_W-1:0]     o_served_arrival_time,
    output logic [drs_pkg::CYL_W-1:0]      o_served_cylinder,
    output logic [drs_pkg::ADR_W-1:0]      o_served_address,
    output logic [drs_pkg::PROC_W-1:0]     o_served_process,
    output logic [drs_pkg::CNT_OUT_W-1:0]  o_waiting_count,
    output logic                           o_dropped
);
    import drs_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = CNT_W + CNT_OUT_W;

    t_state            r_state;
    t_state            n_state;
    logic [POL_W-1:0]  r_policy;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_ptr;
    logic [CYL_W-1:0]  r_head;
    logic              r_up;
    logic              r_act_busy;
    t_entry            r_act;
    logic              r_drop;
    logic              r_scan_v;
    logic [IDX_W-1:0]  r_scan_idx;
    logic              r_mv_v;
    logic [IDX_W-1:0]  r_mv_addr;

    logic              w_accept;
    logic              w_full;
    logic              w_cfg_wr;
    logic              w_ram_we;
    logic [IDX_W-1:0]  w_ram_waddr;
    t_entry            w_ram_wdata;
    t_entry            w_ram_rdata;
    t_entry            w_new;
    t_pick_ctl         w_pick_ctl;
    logic [IDX_W-1:0]  w_best_idx;
    t_entry            w_best_entry;
    logic [CNT_W-1:0]  w_best_next;
    logic [EXT_W-1:0]  w_cnt_ext;

    assign w_accept    = start && !busy;
    assign w_full      = r_count == CNT_W'(QUEUE_DEPTH);
    assign w_cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_POLICY);
    assign w_new       = '{id:       i_new_request_id,
                           arrival:  i_new_arrival_time,
                           cylinder: i_new_cylinder,
                           address:  i_new_address,
                           process:  i_new_process};
    assign w_best_next = CNT_W'(w_best_idx) + CNT_W'(1);

    assign w_ram_we    = (w_accept && !i_mode && r_act_busy && !w_full) || r_mv_v;
    assign w_ram_waddr = r_mv_v ? r_mv_addr : r_count[IDX_W-1:0];
    assign w_ram_wdata = r_mv_v ? w_ram_rdata : w_new;

    assign w_pick_ctl  = '{valid:  r_scan_v,
                           first:  r_scan_idx == '0,
                           head:   r_head,
                           up:     r_up,
                           policy: r_policy};

    drs_ram #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    drs_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .i_clk        (i_clk),
        .i_ctl        (w_pick_ctl),
        .i_idx        (r_scan_idx),
        .i_entry      (w_ram_rdata),
        .o_best_idx   (w_best_idx),
        .o_best_entry (w_best_entry)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_mode && (r_count != '0)) ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN: begin
                if (r_ptr == r_count - CNT_W'(1)) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST:  n_state = ST_TAKE;
            ST_TAKE:  n_state = (w_best_next == r_count) ? ST_RESP : ST_SHIFT;
            ST_SHIFT: begin
                if (r_ptr == r_count) begin
                    n_state = ST_MVLAST;
                end
            end
            ST_MVLAST: n_state = ST_RESP;
            ST_RESP:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy   = r_state != ST_IDLE;
        o_done = r_state == ST_RESP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_policy   <= POL_FCFS;
            r_count    <= '0;
            r_ptr      <= '0;
            r_act_busy <= 1'b0;
            r_act      <= '0;
            r_drop     <= 1'b0;
            r_scan_v   <= 1'b0;
            r_mv_v     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan_v <= r_state == ST_SCAN;
            r_mv_v   <= r_state == ST_SHIFT;
            if (w_cfg_wr) begin
                r_policy <= pwdata[POL_W-1:0];
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_ptr <= '0;
                        if (!i_mode) begin
                            r_drop <= r_act_busy && w_full;
                            if (!r_act_busy) begin
                                r_act_busy <= 1'b1;
                                r_act      <= w_new;
                            end else if (!w_full) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end else begin
                            r_drop <= 1'b0;
                            if (r_count == '0) begin
                                r_act_busy <= 1'b0;
                                r_act      <= '0;
                            end
                        end
                    end
                end
                ST_SCAN:  r_ptr <= r_ptr + CNT_W'(1);
                ST_TAKE: begin
                    r_act_busy <= 1'b1;
                    r_act      <= w_best_entry;
                    r_count    <= r_count - CNT_W'(1);
                    r_ptr      <= w_best_next;
                end
                ST_SHIFT: r_ptr <= r_ptr + CNT_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx <= r_ptr[IDX_W-1:0];
        r_mv_addr  <= r_ptr[IDX_W-1:0] - IDX_W'(1);
        if (w_accept) begin
            r_head <= i_head_cylinder;
            r_up   <= i_scan_direction;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POLICY) ? APB_DW'(r_policy) : '0;

    assign w_cnt_ext             = EXT_W'(r_count);
    assign o_busy_res            = r_act_busy;
    assign o_served_id           = r_act.id;
    assign o_served_arrival_time = r_act.arrival;
    assign o_served_cylinder     = r_act.cylinder;
    assign o_served_address      = r_act.address;
    assign o_served_process      = r_act.process;
    assign o_waiting_count       = w_cnt_ext[CNT_OUT_W-1:0];
    assign o_dropped             = r_drop;

endmodule

### hdl/drs_ram.sv
module drs_ram #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  drs_pkg::t_entry  i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output drs_pkg::t_entry  o_rdata
);
    import drs_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/drs_pick.sv
module drs_pick #(
    parameter int IDX_W = 4
) (
    input  logic               i_clk,
    input  drs_pkg::t_pick_ctl i_ctl,
    input  logic [IDX_W-1:0]   i_idx,
    input  drs_pkg::t_entry    i_entry,
    output logic [IDX_W-1:0]   o_best_idx,
    output drs_pkg::t_entry    o_best_entry
);
    import drs_pkg::*;

    logic [CYL_W-1:0]  w_dist;
    logic              w_above;
    logic              w_below;
    logic              w_ahead;
    logic [KEY_W-1:0]  w_key;
    logic              w_take;

    logic [KEY_W-1:0]  r_best_key;
    logic [IDX_W-1:0]  r_best_idx;
    t_entry            r_best_entry;

    always_comb begin
        w_above = i_entry.cylinder > i_ctl.head;
        w_below = i_entry.cylinder < i_ctl.head;
        w_dist  = w_above ? (i_entry.cylinder - i_ctl.head) : (i_ctl.head - i_entry.cylinder);
        w_ahead = i_ctl.up ? w_above : w_below;
        case (i_ctl.policy)
            POL_FCFS: w_key = {1'b0, {CYL_W{1'b0}}, i_entry.arrival};
            POL_SSTF: w_key = {1'b0, w_dist, i_entry.arrival};
            default:  w_key = {!w_ahead, w_dist,
                               w_ahead ? {TIME_W{1'b0}} : i_entry.arrival};
        endcase
        w_take = i_ctl.valid && (i_ctl.first || (w_key < r_best_key));
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_key   <= w_key;
            r_best_idx   <= i_idx;
            r_best_entry <= i_entry;
        end
    end

    assign o_best_idx   = r_best_idx;
    assign o_best_entry = r_best_entry;

endmodule

### hdl/drs_checker.sv
`include "assert_macros.svh"

module drs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic                         o_busy_res,
    input logic [drs_pkg::ID_W-1:0]     o_served_id,
    input logic [drs_pkg::PROC_W-1:0]   o_served_process,
    input logic                         o_dropped
);
    import drs_pkg::*;

    `DRS_AST_NEXT(a_accept_busy, start && !busy, busy)
    `DRS_AST_NOW(a_done_busy, o_done, busy)
    `DRS_AST_NEXT(a_done_single, o_done, !o_done)
    `DRS_AST_NOW(a_idle_zero, o_done && !o_busy_res, (o_served_id == '0) && (o_served_process == '0))
    `DRS_AST_NOW(a_drop_busy, o_done && o_dropped, o_busy_res)

endmodule

bind disk_request_scheduler_unit drs_checker u_drs_checker (.*);

### tb/disk_request_scheduler_unit_test.sv
`timescale 1ns / 100ps

module disk_request_scheduler_unit_test;

    import drs_pkg::*;

    localparam int WAIT_SLOTS   = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int PLAN_ROWS    = 25;
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int SETTLE       = 40;

    localparam logic MODE_ARRIVE   = 1'b0;
    localparam logic MODE_COMPLETE = 1'b1;

    localparam logic [POL_W-1:0] POL_LOOK    = 2'd2;
    localparam logic [POL_W-1:0] POL_LOOK_HI = 2'd3;

    localparam logic [APB_AW-1:0] ADDR_POLICY = {REG_POLICY, 2'b00};

    typedef struct packed {
        logic              mode;
        t_entry            req;
        logic [CYL_W-1:0]  head;
        logic              up;
    } t_disk_cmd;

    typedef struct packed {
        logic                 busy_bit;
        t_entry               served;
        logic [CNT_OUT_W-1:0] waiting;
        logic                 dropped;
    } t_svc_status;

    typedef struct packed {
        t_disk_cmd   cmd;
        logic        typed;
        t_svc_status exp;
    } t_plan_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;
    logic                   i_mode;
    logic [ID_W-1:0]        i_new_request_id;
    logic [TIME_W-1:0]      i_new_arrival_time;
    logic [CYL_W-1:0]       i_new_cylinder;
    logic [ADR_W-1:0]       i_new_address;
    logic [PROC_W-1:0]      i_new_process;
    logic [CYL_W-1:0]       i_head_cylinder;
    logic                   i_scan_direction;
    logic                   o_done;
    logic                   o_busy_res;
    logic [ID_W-1:0]        o_served_id;
    logic [TIME_W-1:0]      o_served_arrival_time;
    logic [CYL_W-1:0]       o_served_cylinder;
    logic [ADR_W-1:0]       o_served_address;
    logic [PROC_W-1:0]      o_served_process;
    logic [CNT_OUT_W-1:0]   o_waiting_count;
    logic                   o_dropped;

    t_entry          wait_slots [WAIT_SLOTS];
    int              wait_cnt;
    logic            svc_busy;
    t_entry          svc_req;
    logic [POL_W-1:0] policy_now;

    t_svc_status     due_status [$];
    t_plan_row       plan_rows [PLAN_ROWS];
    int              mismatch_count;
    int              cycle_count;

    disk_request_scheduler_unit #(
        .QUEUE_DEPTH(WAIT_SLOTS)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_mode               (i_mode),
        .i_new_request_id     (i_new_request_id),
        .i_new_arrival_time   (i_new_arrival_time),
        .i_new_cylinder       (i_new_cylinder),
        .i_new_address        (i_new_address),
        .i_new_process        (i_new_process),
        .i_head_cylinder      (i_head_cylinder),
        .i_scan_direction     (i_scan_direction),
        .o_done               (o_done),
        .o_busy_res           (o_busy_res),
        .o_served_id          (o_served_id),
        .o_served_arrival_time(o_served_arrival_time),
        .o_served_cylinder    (o_served_cylinder),
        .o_served_address     (o_served_address),
        .o_served_process     (o_served_process),
        .o_waiting_count      (o_waiting_count),
        .o_dropped            (o_dropped)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [CYL_W-1:0] seek_len(logic [CYL_W-1:0] a, logic [CYL_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_svc_status advance_scheduler(t_disk_cmd c);
        t_svc_status      r;
        int               pick;
        logic             found;
        logic [CYL_W-1:0] d;
        logic [CYL_W-1:0] bd;
        logic [CYL_W-1:0] cyl;
        r = '0;
        if (c.mode == MODE_ARRIVE) begin
            if (!svc_busy) begin
                svc_busy = 1'b1;
                svc_req  = c.req;
            end else if (wait_cnt < WAIT_SLOTS) begin
                wait_slots[wait_cnt] = c.req;
                wait_cnt++;
            end else begin
                r.dropped = 1'b1;
            end
        end else if (wait_cnt == 0) begin
            svc_busy = 1'b0;
            svc_req  = '0;
        end else begin
            pick  = 0;
            found = 1'b0;
            bd    = '0;
            if (policy_now == POL_FCFS) begin
                for (int k = 1; k < wait_cnt; k++)
                    if (wait_slots[k].arrival < wait_slots[pick].arrival)
                        pick = k;
                found = 1'b1;
            end else if (policy_now[1]) begin
                for (int k = 0; k < wait_cnt; k++) begin
                    cyl = wait_slots[k].cylinder;
                    if (c.up ? (cyl > c.head) : (cyl < c.head)) begin
                        d = seek_len(cyl, c.head);
                        if (!found || d < bd) begin
                            found = 1'b1;
                            pick  = k;
                            bd    = d;
                        end
                    end
                end
            end
            if (!found) begin
                pick = 0;
                for (int k = 1; k < wait_cnt; k++) begin
                    d  = seek_len(wait_slots[k].cylinder, c.head);
                    bd = seek_len(wait_slots[pick].cylinder, c.head);
                    if (d < bd || (d == bd && wait_slots[k].arrival < wait_slots[pick].arrival))
                        pick = k;
                end
            end
            svc_busy = 1'b1;
            svc_req  = wait_slots[pick];
            for (int k = pick; k + 1 < wait_cnt; k++)
                wait_slots[k] = wait_slots[k + 1];
            wait_cnt--;
        end
        r.busy_bit = svc_busy;
        r.served   = svc_busy ? svc_req : '0;
        r.waiting  = wait_cnt[CNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic t_entry entry(logic [ID_W-1:0] id, logic [TIME_W-1:0] arr,
                                     logic [CYL_W-1:0] cyl, logic [ADR_W-1:0] adr,
                                     logic [PROC_W-1:0] proc);
        t_entry e;
        e.id       = id;
        e.arrival  = arr;
        e.cylinder = cyl;
        e.address  = adr;
        e.process  = proc;
        return e;
    endfunction

    function automatic t_disk_cmd arrive(t_entry e);
        t_disk_cmd c;
        c.mode = MODE_ARRIVE;
        c.req  = e;
        c.head = CYL_W'($urandom);
        c.up   = 1'($urandom);
        return c;
    endfunction

    function automatic t_disk_cmd complete_req(logic [CYL_W-1:0] head, logic up);
        t_disk_cmd c;
        c.mode = MODE_COMPLETE;
        c.req  = entry(ID_W'($urandom), TIME_W'($urandom), CYL_W'($urandom),
                       ADR_W'($urandom), PROC_W'($urandom));
        c.head = head;
        c.up   = up;
        return c;
    endfunction

    function automatic t_svc_status status(logic b, t_entry e, logic [CNT_OUT_W-1:0] n,
                                           logic d);
        t_svc_status s;
        s.busy_bit = b;
        s.served   = e;
        s.waiting  = n;
        s.dropped  = d;
        return s;
    endfunction

    function automatic logic [CYL_W-1:0] pick_cyl();
        case ($urandom_range(3))
            0:       return CYL_W'($urandom);
            1:       return CYL_W'($urandom_range(6));
            2:       return CYL_W'(32'hFFFF - $urandom_range(6));
            default: return CYL_W'(32'h8000 + $urandom_range(6));
        endcase
    endfunction

    function automatic t_disk_cmd draw_cmd(int arrive_pct);
        t_disk_cmd c;
        c.mode        = ($urandom_range(99) < arrive_pct) ? MODE_ARRIVE : MODE_COMPLETE;
        c.req.id      = ID_W'($urandom);
        c.req.arrival = $urandom_range(1) ? $urandom : $urandom_range(5);
        c.req.cylinder = pick_cyl();
        c.req.address = $urandom;
        c.req.process = ($urandom_range(15) == 0) ? '0 : PROC_W'($urandom);
        c.head        = pick_cyl();
        c.up          = 1'($urandom);
        return c;
    endfunction

    function automatic int draw_gap(int idle_pct);
        int g;
        g = 0;
        while ($urandom_range(99) < idle_pct && g < 40)
            g++;
        return g;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_item(input t_disk_cmd c, input int gap, output t_svc_status want);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode             <= c.mode;
        i_new_request_id   <= c.req.id;
        i_new_arrival_time <= c.req.arrival;
        i_new_cylinder     <= c.req.cylinder;
        i_new_address      <= c.req.address;
        i_new_process      <= c.req.process;
        i_head_cylinder    <= c.head;
        i_scan_direction   <= c.up;
        start              <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = advance_scheduler(c);
    endtask

    task automatic write_policy(input logic [POL_W-1:0] value);
        @(negedge i_clk);
        start <= 1'b0;
        while (due_status.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_POLICY;
        pwdata  <= {{(APB_DW-POL_W){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        policy_now = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        t_svc_status want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (due_status.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = due_status.pop_front();
                if (o_busy_res !== want.busy_bit)
                    report_mismatch($sformatf("busy_res got %0d want %0d",
                                              o_busy_res, want.busy_bit));
                if (o_served_id !== want.served.id)
                    report_mismatch($sformatf("served_id got %h want %h",
                                              o_served_id, want.served.id));
                if (o_served_arrival_time !== want.served.arrival)
                    report_mismatch($sformatf("served_arrival_time got %h want %h",
                                              o_served_arrival_time, want.served.arrival));
                if (o_served_cylinder !== want.served.cylinder)
                    report_mismatch($sformatf("served_cylinder got %h want %h",
                                              o_served_cylinder, want.served.cylinder));
                if (o_served_address !== want.served.address)
                    report_mismatch($sformatf("served_address got %h want %h",
                                              o_served_address, want.served.address));
                if (o_served_process !== want.served.process)
                    report_mismatch($sformatf("served_process got %h want %h",
                                              o_served_process, want.served.process));
                if (o_waiting_count !== want.waiting)
                    report_mismatch($sformatf("waiting_count got %0d want %0d",
                                              o_waiting_count, want.waiting));
                if (o_dropped !== want.dropped)
                    report_mismatch($sformatf("dropped got %0d want %0d",
                                              o_dropped, want.dropped));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_svc_status      got;
        t_entry           top;
        logic [POL_W-1:0] pol;
        int               idle_pct;
        int               arrive_pct;

        i_rst_n            = 1'b0;
        start              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        i_mode             = MODE_ARRIVE;
        i_new_request_id   = '0;
        i_new_arrival_time = '0;
        i_new_cylinder     = '0;
        i_new_address      = '0;
        i_new_process      = '0;
        i_head_cylinder    = '0;
        i_scan_direction   = 1'b0;
        wait_cnt           = 0;
        svc_busy           = 1'b0;
        svc_req            = '0;
        policy_now         = POL_FCFS;
        mismatch_count     = 0;
        cycle_count        = 0;

        top = entry(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        plan_rows[0] = '{complete_req(16'h0000, 1'b0), 1'b1,
                         status(1'b0, '0, CNT_OUT_W'(0), 1'b0)};
        plan_rows[1] = '{arrive(top), 1'b1, status(1'b1, top, CNT_OUT_W'(0), 1'b0)};
        plan_rows[2] = '{arrive('0), 1'b1, status(1'b1, top, CNT_OUT_W'(1), 1'b0)};
        for (int i = 0; i < 15; i++)
            plan_rows[3 + i] = '{arrive(entry(ID_W'(16'h0100 + i), TIME_W'((14 - i) % 5),
                                              CYL_W'(i * 16'h1000 + (i % 2)),
                                              ADR_W'(~i), PROC_W'(i + 1))),
                                 1'b0, '0};
        plan_rows[18] = '{arrive(entry(16'h5A5A, 32'h1, 16'h8000, 32'h5A5A_5A5A, 16'h0001)),
                          1'b1, status(1'b1, top, CNT_OUT_W'(16), 1'b1)};
        plan_rows[19] = '{complete_req(16'h0000, 1'b1), 1'b0, '0};
        plan_rows[20] = '{complete_req(16'hFFFF, 1'b0), 1'b0, '0};
        plan_rows[21] = '{complete_req(16'h8000, 1'b1), 1'b0, '0};
        plan_rows[22] = '{complete_req(16'h3000, 1'b0), 1'b0, '0};
        plan_rows[23] = '{complete_req(16'h0000, 1'b0), 1'b0, '0};
        plan_rows[24] = '{complete_req(16'hFFFF, 1'b1), 1'b0, '0};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            send_item(plan_rows[r].cmd, 0, got);
            due_status.push_back(plan_rows[r].typed ? plan_rows[r].exp : got);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0:       pol = POL_FCFS;
                1:       pol = POL_SSTF;
                2:       pol = POL_LOOK;
                default: pol = POL_LOOK_HI;
            endcase
            case (ph % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 59;
                default: idle_pct = 27;
            endcase
            arrive_pct = 45 + (ph * 7) % 30;
            write_policy(pol);
            repeat (PHASE_ITEMS) begin
                send_item(draw_cmd(arrive_pct), draw_gap(idle_pct), got);
                due_status.push_back(got);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (due_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatch_count == 0 && due_status.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/drs_pkg.sv
hdl/drs_ram.sv
hdl/drs_pick.sv
hdl/disk_request_scheduler_unit.sv
hdl/drs_checker.sv
tb/disk_request_scheduler_unit_test.sv
